// ===== src/d2i_pkg.sv =====
package d2i_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned VALUE_W = 32;

  // Largest magnitude that may still take one more digit, if that digit is within the limit below.
  localparam logic [VALUE_W-1:0] MAG_BORDER = 32'd214748364;
  localparam logic [3:0] LAST_DIGIT_POS = 4'd7;
  localparam logic [3:0] LAST_DIGIT_NEG = 4'd8;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CH_PLUS = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'd57;

  typedef enum logic [1:0] {
    PHASE_BLANKS = 2'd0,
    PHASE_DIGITS = 2'd1,
    PHASE_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic               negative;
    logic [VALUE_W-1:0] magnitude;
  } parse_state_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic               overflow;
  } parse_result_t;

endpackage

// ===== src/d2i_step.sv =====
module d2i_step
  import d2i_pkg::*;
(
  input  parse_state_t      cur,
  input  logic [CHAR_W-1:0] char_byte,
  input  logic              string_start,
  output parse_state_t      nxt,
  output parse_result_t     res
);

  parse_state_t       base;
  logic               is_blank;
  logic               is_digit;
  logic [3:0]         digit;
  logic [3:0]         limit;
  logic               digit_ovf;
  logic [VALUE_W-1:0] mag_times_ten;

  assign base.phase = string_start ? PHASE_BLANKS : cur.phase;
  assign base.negative = string_start ? 1'b0 : cur.negative;
  assign base.magnitude = string_start ? '0 : cur.magnitude;

  assign is_blank = (char_byte == CH_SPACE) || (char_byte >= CH_TAB && char_byte <= CH_CR);
  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign digit = 4'(char_byte - CH_ZERO);
  assign limit = base.negative ? LAST_DIGIT_NEG : LAST_DIGIT_POS;
  assign digit_ovf = (base.magnitude > MAG_BORDER) ||
                     ((base.magnitude == MAG_BORDER) && (digit > limit));
  // Times ten as two shifts; the border check keeps this from wrapping.
  assign mag_times_ten = {base.magnitude[VALUE_W-4:0], 3'b000} +
                         {base.magnitude[VALUE_W-2:0], 1'b0};

  always_comb begin
    nxt = base;
    res.valid = 1'b0;
    res.value = '0;
    res.overflow = 1'b0;
    case (base.phase)
      PHASE_BLANKS, PHASE_DIGITS: begin
        if (is_digit) begin
          if (digit_ovf) begin
            res.valid = 1'b1;
            res.overflow = 1'b1;
            nxt.phase = PHASE_DONE;
          end else begin
            nxt.magnitude = mag_times_ten + VALUE_W'(digit);
            nxt.phase = PHASE_DIGITS;
          end
        end else if (base.phase == PHASE_BLANKS && is_blank) begin
          nxt.phase = PHASE_BLANKS;
        end else if (base.phase == PHASE_BLANKS && char_byte == CH_MINUS) begin
          nxt.negative = 1'b1;
          nxt.phase = PHASE_DIGITS;
        end else if (base.phase == PHASE_BLANKS && char_byte == CH_PLUS) begin
          nxt.phase = PHASE_DIGITS;
        end else begin
          // Any other byte ends the number; with no digits the magnitude is zero.
          res.valid = 1'b1;
          res.value = base.negative ? (VALUE_W'(0) - base.magnitude) : base.magnitude;
          nxt.phase = PHASE_DONE;
        end
      end
      default: begin
        nxt = base;
      end
    endcase
  end

endmodule

// ===== src/decimal_to_int32_parser_unit.sv =====
// Channel  Direction  tdata                 tuser
// s_axis   in         [7:0] char_byte       [0] string_start
// m_axis   out        [31:0] parsed_value   [0] overflow
//
// One byte per cycle: a beat is registered, then parsed by the digit logic
// (a multiply by ten as two shifts and an add) into the result register.
// Bytes that end no number give no result beat. Synchronous reset leaves
// the parser done, so bytes before the first string start are dropped. A
// stalled result holds the pipeline; the input side keeps taking beats
// while it can drain.
module decimal_to_int32_parser_unit
  import d2i_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [CHAR_W-1:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic               s_axis_tuser,   // [0] string_start
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [VALUE_W-1:0] m_axis_tdata,   // [31:0] parsed_value
  output logic               m_axis_tuser    // [0] overflow
);

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_start;
  logic              advance;
  parse_state_t      state;
  parse_state_t      state_next;
  parse_result_t     step_res;

  assign advance = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  d2i_step u_step (
    .cur          (state),
    .char_byte    (in_char),
    .string_start (in_start),
    .nxt          (state_next),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PHASE_DONE;
      state.negative <= 1'b0;
      state.magnitude <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && step_res.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      m_axis_tdata <= step_res.value;
      m_axis_tuser <= step_res.overflow;
    end
  end

endmodule
